// ===== hdl/bitshuffle_transpose_top_assert.svh =====
// ---------------------------------------------------------------------------
// bitshuffle transpose assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef BITSHUFFLE_TRANSPOSE_TOP_ASSERT_SVH
`define BITSHUFFLE_TRANSPOSE_TOP_ASSERT_SVH

// same-cycle implication
`define BST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bst same-cycle check failed");

// next-cycle implication
`define BST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bst next-cycle check failed");

`endif

// ===== hdl/bst_pkg.sv =====
// ---------------------------------------------------------------------------
// bst_pkg
// constants, codes and types shared by the bitshuffle transpose block
// ---------------------------------------------------------------------------
package bst_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int WORD_W     = 64;
    localparam int LANES      = 8;
    localparam int ADDR_W     = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int BYTE_AW    = ADDR_W + 3;
    localparam int GRP_W      = $clog2(MAX_WORDS / 2 + 1);
    localparam int GIDX_W     = $clog2(MAX_WORDS / 2);
    localparam int PROD_W     = 6 + GRP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;

    localparam logic [1:0] ELEM_2B = 2'd0;
    localparam logic [1:0] ELEM_4B = 2'd1;
    localparam logic [1:0] ELEM_8B = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EMIT,
        ST_DRAIN,
        ST_PUT,
        ST_ERR
    } state_t;

    // read request handed to every lane
    typedef struct packed {
        logic              inv;
        logic [1:0]        lw;
        logic [GRP_W-1:0]  groups;
        logic [GIDX_W-1:0] g;
        logic [2:0]        b;
        logic [2:0]        k;
    } lane_ctl_t;

endpackage

// ===== hdl/bst_ram.sv =====
// ---------------------------------------------------------------------------
// bst_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module bst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bst_lane.sv =====
// ---------------------------------------------------------------------------
// bst_lane
// one bit lane: own copy of the block buffer; while rd_en is high it picks one bit per cycle
// ---------------------------------------------------------------------------
module bst_lane import bst_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [2:0]        lane_idx,
    input  lane_ctl_t         ctl,
    output logic              bit_out
);

    logic [BYTE_AW-1:0] fwd_addr;
    logic [BYTE_AW-1:0] inv_addr;
    logic [BYTE_AW-1:0] byte_addr;
    logic [PROD_W-1:0]  plane;
    logic [WORD_W-1:0]  rd_data;
    logic [5:0]         sel_reg;
    logic [5:0]         sel_next;

    // forward: byte (g*8 + lane)*w + b of the block
    assign fwd_addr = ((BYTE_AW'(ctl.g) << 3) << ctl.lw)
                    + (BYTE_AW'(lane_idx) << ctl.lw)
                    + BYTE_AW'(ctl.b);
    // inverse: plane byte (b*8 + lane)*groups + g
    assign plane    = PROD_W'({ctl.b, lane_idx}) * PROD_W'(ctl.groups) + PROD_W'(ctl.g);
    assign inv_addr = plane[BYTE_AW-1:0];

    assign byte_addr = ctl.inv ? inv_addr : fwd_addr;
    assign sel_next  = {byte_addr[2:0], ctl.k};

    bst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (byte_addr[BYTE_AW-1:3]),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            sel_reg <= sel_next;
        end
    end

    assign bit_out = rd_data[sel_reg];

endmodule

// ===== hdl/bitshuffle_transpose_top.sv =====
// loading: one word per cycle, a new word can follow in the next cycle
// emit: per result word, eight byte reads through the lane rams (ST_EMIT), a read
// drain (ST_DRAIN) and an output load (ST_PUT) held while the output is stalled
// an error result is loaded into the output registers from ST_ERR once the output is free
// aresetn is synchronous, active low: element width 4 bytes, forward, buffer empty
// ---------------------------------------------------------------------------
// bitshuffle_transpose_top
// bit-plane transpose, or its inverse, of a block of 64-bit words over eight bit lanes
// ---------------------------------------------------------------------------
`include "bitshuffle_transpose_top_assert.svh"

module bitshuffle_transpose_top import bst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_data_word,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_out_word,
    output logic                  m_out_last,
    output logic [1:0]            m_status
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   wc_reg, wc_next;
    logic               ovf_reg, ovf_next;
    logic [1:0]         elem_code_reg;
    logic               dir_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [1:0]         lw_reg, lw_next;
    logic [GRP_W-1:0]   groups_reg, groups_next;
    logic               inv_reg, inv_next;
    status_t            err_reg, err_next;
    logic [GIDX_W-1:0]  g_reg, g_next;
    logic [2:0]         b_reg, b_next;
    logic [2:0]         k_reg, k_next;
    logic [2:0]         byte_reg, byte_next;
    logic [ADDR_W-1:0]  outk_reg, outk_next;
    logic               rd_v_reg, rd_v_next;
    logic [2:0]         rd_pos_reg;
    logic [WORD_W-1:0]  asm_reg;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  m_word_reg, m_word_next;
    logic               m_last_reg, m_last_next;
    status_t            m_status_reg, m_status_next;

    logic               in_acc;
    logic               wc_full;
    logic [CNT_W-1:0]   blk_n;
    logic               blk_ovf;
    logic [1:0]         lw_cfg;
    logic               code_ok;
    logic               blk_bad;
    logic               out_free;
    logic               last_word;
    logic [2:0]         bmax;
    logic [GIDX_W-1:0]  gmax;
    logic               rd_en;
    lane_ctl_t          ctl;
    logic [LANES-1:0]   lane_bits;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_acc   = s_valid && s_ready;
    assign wc_full  = (wc_reg == CNT_W'(MAX_WORDS));
    assign blk_n    = wc_full ? wc_reg : wc_reg + CNT_W'(1);
    assign blk_ovf  = ovf_reg || wc_full;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        lw_cfg  = 2'd2;
        code_ok = 1'b1;
        unique case (elem_code_reg)
            ELEM_2B: lw_cfg = 2'd1;
            ELEM_4B: lw_cfg = 2'd2;
            ELEM_8B: lw_cfg = 2'd3;
            default: code_ok = 1'b0;
        endcase
    end

    assign blk_bad   = blk_ovf || !code_ok
                    || ((blk_n & CNT_W'((CNT_W'(1) << lw_cfg) - CNT_W'(1))) != '0);
    assign last_word = (CNT_W'(outk_reg) + CNT_W'(1) == n_reg);
    assign bmax      = 3'((4'd1 << lw_reg) - 4'd1);
    assign gmax      = GIDX_W'(groups_reg - GRP_W'(1));
    assign rd_en     = (state_reg == ST_EMIT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_last) begin
                    state_next = blk_bad ? ST_ERR : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (byte_reg == 3'd7) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_PUT;
            ST_PUT: begin
                if (out_free) begin
                    state_next = last_word ? ST_LOAD : ST_EMIT;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        wc_next       = wc_reg;
        ovf_next      = ovf_reg;
        n_next        = n_reg;
        lw_next       = lw_reg;
        groups_next   = groups_reg;
        inv_next      = inv_reg;
        err_next      = err_reg;
        g_next        = g_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        byte_next     = byte_reg;
        outk_next     = outk_reg;
        rd_v_next     = rd_en;
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (wc_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        wc_next = wc_reg + CNT_W'(1);
                    end
                    if (s_last) begin
                        wc_next     = '0;
                        ovf_next    = 1'b0;
                        n_next      = blk_n;
                        lw_next     = lw_cfg;
                        groups_next = GRP_W'(blk_n >> lw_cfg);
                        inv_next    = dir_reg;
                        err_next    = blk_ovf ? STATUS_OVERFLOW : STATUS_BAD_LEN;
                        g_next      = '0;
                        b_next      = '0;
                        k_next      = '0;
                        byte_next   = '0;
                        outk_next   = '0;
                    end
                end
            end
            ST_EMIT: begin
                byte_next = byte_reg + 3'd1;
                if (inv_reg) begin
                    // element order: byte fastest, then lane, then group
                    if (b_reg == bmax) begin
                        b_next = '0;
                        if (k_reg == 3'd7) begin
                            k_next = '0;
                            g_next = g_reg + GIDX_W'(1);
                        end else begin
                            k_next = k_reg + 3'd1;
                        end
                    end else begin
                        b_next = b_reg + 3'd1;
                    end
                end else begin
                    // plane order: group fastest, then bit, then byte
                    if (g_reg == gmax) begin
                        g_next = '0;
                        if (k_reg == 3'd7) begin
                            k_next = '0;
                            b_next = b_reg + 3'd1;
                        end else begin
                            k_next = k_reg + 3'd1;
                        end
                    end else begin
                        g_next = g_reg + GIDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
            end
            ST_PUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = asm_reg;
                    m_last_next   = last_word;
                    m_status_next = STATUS_OK;
                    outk_next     = outk_reg + ADDR_W'(1);
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = '0;
                    m_last_next   = 1'b1;
                    m_status_next = err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctl.inv    = inv_reg;
    assign ctl.lw     = lw_reg;
    assign ctl.groups = groups_reg;
    assign ctl.g      = g_reg;
    assign ctl.b      = b_reg;
    assign ctl.k      = k_reg;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        bst_lane u_lane (
            .aclk     (aclk),
            .wr_en    (in_acc && !wc_full),
            .wr_addr  (wc_reg[ADDR_W-1:0]),
            .wr_data  (s_data_word),
            .rd_en    (rd_en),
            .lane_idx (3'(i)),
            .ctl      (ctl),
            .bit_out  (lane_bits[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            wc_reg        <= '0;
            ovf_reg       <= 1'b0;
            elem_code_reg <= ELEM_4B;
            dir_reg       <= 1'b0;
            rd_v_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wc_reg      <= wc_next;
            ovf_reg     <= ovf_next;
            rd_v_reg    <= rd_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                priority if (cfg_index == REG_ELEM_SIZE) begin
                    elem_code_reg <= cfg_wdata[1:0];
                end else if (cfg_index == REG_DIRECTION) begin
                    dir_reg <= cfg_wdata[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        lw_reg       <= lw_next;
        groups_reg   <= groups_next;
        inv_reg      <= inv_next;
        err_reg      <= err_next;
        g_reg        <= g_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        byte_reg     <= byte_next;
        outk_reg     <= outk_next;
        rd_pos_reg   <= byte_reg;
        m_word_reg   <= m_word_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
        // merge: the eight lane bits form one byte of the result word
        if (rd_v_reg) begin
            asm_reg[{rd_pos_reg, 3'b000} +: 8] <= lane_bits;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_word = m_word_reg;
    assign m_out_last = m_last_reg;
    assign m_status   = m_status_reg;

    `BST_ASSERT_IMP(a_err_result_zero, m_valid && m_status != 2'(STATUS_OK), m_out_word == '0 && m_out_last)
    `BST_ASSERT_NXT(a_last_ends_load, s_valid && s_ready && s_last, !s_ready)
    `BST_ASSERT_IMP(a_count_bound, 1'b1, wc_reg <= CNT_W'(MAX_WORDS))

endmodule

// ===== test/bst_checker.sv =====
// ---------------------------------------------------------------------------
// bst_checker
// watches the register port and both channels of the bitshuffle block,
// predicts every result word and compares it with what comes out
// ---------------------------------------------------------------------------
module bst_checker import bst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [WORD_W-1:0]     s_data_word,
    input  logic                  s_last,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [WORD_W-1:0]     m_out_word,
    input  logic                  m_out_last,
    input  logic [1:0]            m_status,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        status_t           status;
    } shuffle_res_t;

    shuffle_res_t      shuffled_q[$];
    logic [WORD_W-1:0] held_words [MAX_WORDS];
    int                held_cnt;
    logic              dropped;
    logic [1:0]        esz_code;
    logic              inverse;
    logic [7:0]        src_b [MAX_WORDS*8];
    logic [7:0]        dst_b [MAX_WORDS*8];

    // queue the whole shuffled (or unshuffled) block, or a single error result
    task automatic shuffle_block(input int n);
        int w, groups, plane, elem;
        logic [WORD_W-1:0] wd;
        shuffle_res_t r;
        w = (esz_code == ELEM_2B) ? 2 : (esz_code == ELEM_4B) ? 4 :
            (esz_code == ELEM_8B) ? 8 : 0;
        if (dropped) begin
            r = '{word: '0, last: 1'b1, status: STATUS_OVERFLOW};
            shuffled_q.push_back(r);
            return;
        end
        if (w == 0 || n == 0 || (n % w) != 0) begin
            r = '{word: '0, last: 1'b1, status: STATUS_BAD_LEN};
            shuffled_q.push_back(r);
            return;
        end
        groups = n / w;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < 8; i++) begin
                src_b[k*8+i] = held_words[k][8*i +: 8];
                dst_b[k*8+i] = 8'h00;
            end
        for (int g = 0; g < groups; g++)
            for (int b = 0; b < w; b++)
                for (int bt = 0; bt < 8; bt++)
                    for (int ln = 0; ln < LANES; ln++) begin
                        plane = (b*8 + bt)*groups + g;
                        elem  = (g*LANES + ln)*w + b;
                        if (!inverse)
                            dst_b[plane][ln] = src_b[elem][bt];
                        else
                            dst_b[elem][bt] = src_b[plane][ln];
                    end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 8; i++) wd[8*i +: 8] = dst_b[k*8+i];
            r = '{word: wd, last: (k == n-1), status: STATUS_OK};
            shuffled_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        shuffle_res_t e;
        if (!aresetn) begin
            shuffled_q.delete();
            held_cnt   = 0;
            dropped    = 1'b0;
            esz_code   = ELEM_4B;
            inverse    = 1'b0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (shuffled_q.size() == 0) begin
                    $display("%0t: unexpected result word %h last %b status %0d",
                             $time, m_out_word, m_out_last, m_status);
                    fail_count = fail_count + 1;
                end else begin
                    e = shuffled_q.pop_front();
                    if (m_out_word !== e.word || m_out_last !== e.last ||
                        m_status !== e.status) begin
                        $display("%0t: mismatch expected %h/%b/%0d actual %h/%b/%0d",
                                 $time, e.word, e.last, e.status,
                                 m_out_word, m_out_last, m_status);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_ELEM_SIZE) esz_code = cfg_wdata[1:0];
                else if (cfg_index == REG_DIRECTION) inverse = cfg_wdata[0];
            end
            if (s_valid && s_ready) begin
                if (held_cnt < MAX_WORDS) begin
                    held_words[held_cnt] = s_data_word;
                    held_cnt = held_cnt + 1;
                end else begin
                    dropped = 1'b1;
                end
                if (s_last) begin
                    shuffle_block(held_cnt);
                    held_cnt = 0;
                    dropped  = 1'b0;
                end
            end
        end
        pending = shuffled_q.size();
    end

endmodule

// ===== test/tb_bitshuffle_transpose_top.sv =====
// ---------------------------------------------------------------------------
// tb_bitshuffle_transpose_top
// drives blocks of words through the bitshuffle block under several element
// widths and both directions, with random stalls; the checker judges results
// ---------------------------------------------------------------------------
module tb_bitshuffle_transpose_top import bst_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_data_word;
    logic                  s_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [WORD_W-1:0]     m_out_word;
    logic                  m_out_last;
    logic [1:0]            m_status;
    int                    fail_count;
    int                    pending;
    logic                  idle_en;
    logic                  long_hold;

    bitshuffle_transpose_top u_top (.*);

    bst_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, and one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        gap = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
                m_ready <= 1'b1;
            end else if (gap > 0) begin
                gap = gap - 1;
                m_ready <= (gap == 0);
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] d, input logic l);
        s_valid     <= 1'b1;
        s_data_word <= d;
        s_last      <= l;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_block(input int n, input int pattern);
        logic [WORD_W-1:0] d;
        for (int k = 0; k < n; k++) begin
            case (pattern)
                1: d = '1;
                2: d = (k % 2) ? '1 : '0;
                default: d = {$urandom, $urandom};
            endcase
            send_word(d, k == n-1);
        end
    endtask

    // wait for the block to go idle, then write a register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int w, n, wait_cnt;
        logic [1:0] code;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_word = '0;
        s_last      = 1'b0;
        idle_en     = 1'b1;
        long_hold   = 1'b0;
        aresetn     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: 4-byte elements, forward
        send_block(4, 1);
        send_block(4, 2);
        send_block(1, 0);
        write_reg(REG_ELEM_SIZE, ELEM_2B);
        write_reg(REG_DIRECTION, 2'd1);
        send_block(2, 0);
        send_block(3, 0);
        write_reg(REG_ELEM_SIZE, ELEM_8B);
        write_reg(REG_DIRECTION, 2'd0);
        send_block(8, 0);
        // reserved element code, and writes to indexes outside the list
        write_reg(REG_ELEM_SIZE, 2'd3);
        write_reg(2'd3, 2'd2);
        write_reg(2'd2, 2'd1);
        send_block(2, 0);

        for (int ph = 0; ph < 4; ph++) begin
            if (ph >= 3) idle_en = 1'b0;
            code = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            write_reg(REG_ELEM_SIZE, code);
            write_reg(REG_DIRECTION, 2'($urandom_range(0, 1)));
            w = (code == ELEM_2B) ? 2 : (code == ELEM_4B) ? 4 : 8;
            if (ph == 1) long_hold = 1'b1;
            // a second block keeps the sender offering words during the hold-off
            for (int blk = 0; blk < ((ph == 1) ? 2 : 1); blk++) begin
                if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 9);
                else n = w * $urandom_range(1, (w == 8) ? 1 : 2);
                send_block(n, 0);
            end
            if (ph == 2) send_block(MAX_WORDS + $urandom_range(1, 2), 0);
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        @(posedge aclk);
        while (pending != 0 && wait_cnt < 100_000) begin
            @(posedge aclk);
            wait_cnt = wait_cnt + 1;
        end
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
